// File: sv/lavm_pkg.sv
`timescale 1ns / 1ps

package lavm_pkg;

    localparam int FRAC_BITS = 16;

    // unit vector component: magnitude up to 2^FRAC_BITS, signed
    localparam int UW        = FRAC_BITS + 2;
    localparam int NORM_IW   = 64;
    localparam int MW        = 30;
    localparam int SQW       = 62;
    localparam int SQ_STEPS  = 31;
    localparam int RTW       = 31;
    localparam int REMW      = 34;
    localparam int NW        = MW + 1 + FRAC_BITS;
    localparam int QW        = FRAC_BITS + 1;
    localparam int DRW       = 32;
    localparam int DIV_STEPS = QW;
    localparam int NORM_LAT  = 5 + SQ_STEPS + 1 + DIV_STEPS + 1;

    typedef struct packed {
        logic [2:0][MW-1:0] m;
        logic [2:0]         sgn;
        logic               zero;
        logic [SQW-1:0]     n;
        logic [REMW-1:0]    rem;
        logic [RTW-1:0]     root;
    } lavm_sq_t;

    typedef struct packed {
        logic [2:0][NW-1:0]  num;
        logic [2:0][DRW-1:0] rem;
        logic [2:0][QW-1:0]  q;
        logic [RTW-1:0]      len;
        logic [2:0]          sgn;
        logic                zero;
    } lavm_dv_t;

endpackage

// File: sv/lavm_norm.sv
`timescale 1ns / 1ps

module lavm_norm
    import lavm_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [2:0][NORM_IW-1:0]    vec_in,
    output logic [2:0][UW-1:0]         vec_out
);

    logic [2:0][NORM_IW-1:0] a_mag_next;
    logic [NORM_IW-1:0]      a_max_next;
    logic [2:0][NORM_IW-1:0] a_mag_reg;
    logic [NORM_IW-1:0]      a_max_reg;
    logic [2:0]              a_sgn_reg;

    logic [6:0]              b_bits_next;
    logic [2:0][NORM_IW-1:0] b_mag_reg;
    logic [2:0]              b_sgn_reg;
    logic [6:0]              b_bits_reg;
    logic                    b_zero_reg;

    logic [2:0][MW-1:0]      c_m_next;
    logic [2:0][MW-1:0]      c_m_reg;
    logic [2:0]              c_sgn_reg;
    logic                    c_zero_reg;

    logic [2:0][2*MW-1:0]    d_sq_reg;
    logic [2:0][MW-1:0]      d_m_reg;
    logic [2:0]              d_sgn_reg;
    logic                    d_zero_reg;

    lavm_sq_t                sq_reg [0:SQ_STEPS];
    lavm_dv_t                dv_reg [0:DIV_STEPS];
    lavm_dv_t                dv_next;
    logic [2:0][UW-1:0]      vec_out_reg;

    // stage A: magnitudes and largest one
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = vec_in[i][NORM_IW-1] ? NORM_IW'(-$signed(vec_in[i])) : vec_in[i];
        end
        a_max_next = a_mag_next[0];
        if (a_mag_next[1] > a_max_next)
        begin
            a_max_next = a_mag_next[1];
        end
        if (a_mag_next[2] > a_max_next)
        begin
            a_max_next = a_mag_next[2];
        end
    end

    // stage B: bit length of the largest magnitude
    always_comb
    begin
        b_bits_next = 7'd0;
        for (int k = 0; k < NORM_IW; k++)
        begin
            if (a_max_reg[k])
            begin
                b_bits_next = 7'(k + 1);
            end
        end
    end

    // stage C: bring the largest magnitude into [2^29, 2^30)
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_bits_reg > 7'(MW))
            begin
                c_m_next[i] = MW'(b_mag_reg[i] >> (b_bits_reg - 7'(MW)));
            end
            else
            begin
                c_m_next[i] = MW'(b_mag_reg[i] << (7'(MW) - b_bits_reg));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mag_reg  <= a_mag_next;
            a_max_reg  <= a_max_next;
            for (int i = 0; i < 3; i++)
            begin
                a_sgn_reg[i] <= vec_in[i][NORM_IW-1];
            end

            b_mag_reg  <= a_mag_reg;
            b_sgn_reg  <= a_sgn_reg;
            b_bits_reg <= b_bits_next;
            b_zero_reg <= (a_max_reg == '0);

            c_m_reg    <= c_m_next;
            c_sgn_reg  <= b_sgn_reg;
            c_zero_reg <= b_zero_reg;

            for (int i = 0; i < 3; i++)
            begin
                d_sq_reg[i] <= (2*MW)'(c_m_reg[i]) * (2*MW)'(c_m_reg[i]);
            end
            d_m_reg    <= c_m_reg;
            d_sgn_reg  <= c_sgn_reg;
            d_zero_reg <= c_zero_reg;

            sq_reg[0].n    <= SQW'(d_sq_reg[0]) + SQW'(d_sq_reg[1]) + SQW'(d_sq_reg[2]);
            sq_reg[0].rem  <= '0;
            sq_reg[0].root <= '0;
            sq_reg[0].m    <= d_m_reg;
            sq_reg[0].sgn  <= d_sgn_reg;
            sq_reg[0].zero <= d_zero_reg;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 1; k <= SQ_STEPS; k++)
    begin : g_sq
        lavm_sq_t        step_next;
        logic [REMW-1:0] rem_t;
        logic [REMW-1:0] trial;

        always_comb
        begin
            step_next   = sq_reg[k-1];
            step_next.n = {sq_reg[k-1].n[SQW-3:0], 2'b00};
            rem_t = {sq_reg[k-1].rem[REMW-3:0], sq_reg[k-1].n[SQW-1:SQW-2]};
            trial = {1'b0, sq_reg[k-1].root, 2'b01};
            if (rem_t >= trial)
            begin
                step_next.rem  = rem_t - trial;
                step_next.root = {sq_reg[k-1].root[RTW-2:0], 1'b1};
            end
            else
            begin
                step_next.rem  = rem_t;
                step_next.root = {sq_reg[k-1].root[RTW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[k] <= step_next;
            end
        end
    end

    // divider setup: rounded numerator, top bits already below the length
    always_comb
    begin
        dv_next.len  = sq_reg[SQ_STEPS].root;
        dv_next.sgn  = sq_reg[SQ_STEPS].sgn;
        dv_next.zero = sq_reg[SQ_STEPS].zero;
        for (int i = 0; i < 3; i++)
        begin
            dv_next.num[i] = (NW'(sq_reg[SQ_STEPS].m[i]) << FRAC_BITS)
                           + NW'(sq_reg[SQ_STEPS].root[RTW-1:1]);
            dv_next.rem[i] = DRW'(dv_next.num[i][NW-1:QW]);
            dv_next.q[i]   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0] <= dv_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_dv
        lavm_dv_t       step_next;
        logic [DRW-1:0] t;

        always_comb
        begin
            step_next = dv_reg[j-1];
            t = '0;
            for (int i = 0; i < 3; i++)
            begin
                t = {dv_reg[j-1].rem[i][DRW-2:0], dv_reg[j-1].num[i][DIV_STEPS-j]};
                if (t >= {1'b0, dv_reg[j-1].len})
                begin
                    step_next.rem[i] = t - {1'b0, dv_reg[j-1].len};
                    step_next.q[i]   = {dv_reg[j-1].q[i][QW-2:0], 1'b1};
                end
                else
                begin
                    step_next.rem[i] = t;
                    step_next.q[i]   = {dv_reg[j-1].q[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j] <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_reg[DIV_STEPS].zero)
                begin
                    vec_out_reg[i] <= '0;
                end
                else if (dv_reg[DIV_STEPS].sgn[i])
                begin
                    vec_out_reg[i] <= UW'(0) - UW'(dv_reg[DIV_STEPS].q[i]);
                end
                else
                begin
                    vec_out_reg[i] <= UW'(dv_reg[DIV_STEPS].q[i]);
                end
            end
        end
    end

    assign vec_out = vec_out_reg;

endmodule

// File: sv/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
// channel  | handshake                      | payload
// ---------+--------------------------------+-------------------------------------
// input    | in_valid / in_stall            | eye_*, target_*, upref_*
// output   | out_valid / out_stall          | right_*, camup_*, back_* and shifts
//
// One request per cycle while the output is not stalled. Each of the three
// normalizers holds a 31-stage square root and FRAC_BITS+1 stage dividers;
// unit vector outputs are Q16.16. Reset clears only the valid bits.
// A stall on a valid output freezes every stage at once; in_stall follows it.

module look_at_view_matrix_unit
    import lavm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] eye_x,
    input  logic signed [31:0] eye_y,
    input  logic signed [31:0] eye_z,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] upref_x,
    input  logic signed [31:0] upref_y,
    input  logic signed [31:0] upref_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] right_x,
    output logic signed [31:0] right_y,
    output logic signed [31:0] right_z,
    output logic signed [31:0] right_shift,
    output logic signed [31:0] camup_x,
    output logic signed [31:0] camup_y,
    output logic signed [31:0] camup_z,
    output logic signed [31:0] camup_shift,
    output logic signed [31:0] back_x,
    output logic signed [31:0] back_y,
    output logic signed [31:0] back_z,
    output logic signed [31:0] back_shift
);

    localparam int NL  = NORM_LAT;
    localparam int TOT = 3 * NL + 9;
    localparam int PW1 = UW + 32;
    localparam int CW1 = PW1 + 1;
    localparam int PW2 = 2 * UW;
    localparam int CW2 = PW2 + 1;
    localparam int PD  = UW + 32;
    localparam int DW  = PD + 2;

    typedef logic [2:0][31:0] vec32_t;
    typedef logic [2:0][UW-1:0] unit_t;

    typedef struct packed {
        vec32_t eye;
        vec32_t up;
    } d1_t;

    typedef struct packed {
        vec32_t eye;
        unit_t  front;
    } d2_t;

    typedef struct packed {
        vec32_t eye;
        unit_t  front;
        unit_t  side;
    } d3_t;

    logic                  en;
    logic                  vld_reg [0:TOT-1];

    vec32_t                i_eye_reg, i_tgt_reg, i_up_reg;
    logic [2:0][32:0]      dir_reg;
    vec32_t                r_eye_reg, r_up_reg;
    d1_t                   d1_reg [0:NL-1];
    d2_t                   d2_reg [0:NL-1];
    d3_t                   d3_reg [0:NL-1];

    logic signed [PW1-1:0] p1_reg [0:5];
    vec32_t                x1_eye_reg;
    unit_t                 x1_front_reg;
    logic signed [CW1-1:0] c1_reg [0:2];
    vec32_t                x2_eye_reg;
    unit_t                 x2_front_reg;

    logic signed [PW2-1:0] p2_reg [0:5];
    vec32_t                y1_eye_reg;
    unit_t                 y1_front_reg, y1_side_reg;
    logic signed [CW2-1:0] c2_reg [0:2];
    vec32_t                y2_eye_reg;
    unit_t                 y2_front_reg, y2_side_reg;

    logic signed [PD-1:0]  dp_reg [0:8];
    unit_t                 z1_front_reg, z1_side_reg, z1_camup_reg;
    logic signed [DW-1:0]  s_reg [0:2];
    unit_t                 z2_front_reg, z2_side_reg, z2_camup_reg;

    logic [2:0][NORM_IW-1:0] n1_in, n2_in, n3_in;
    unit_t                   front_w, side_w, camup_w;

    logic [31:0] o_right_reg [0:3];
    logic [31:0] o_camup_reg [0:3];
    logic [31:0] o_back_reg  [0:3];

    function automatic logic [31:0] round_sat(input logic signed [DW-1:0] v);
        logic [DW-1:0] mag;
        logic [DW-1:0] r;
        logic [31:0]   res;
        mag = v[DW-1] ? DW'(-v) : DW'(v);
        r   = (mag + (DW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!v[DW-1])
        begin
            res = (r > DW'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[31:0];
        end
        else
        begin
            res = (r > DW'(64'h8000_0000)) ? 32'h8000_0000 : 32'd0 - r[31:0];
        end
        return res;
    endfunction

    assign en       = !vld_reg[TOT-1] || !out_stall;
    assign in_stall = !en;
    assign out_valid = vld_reg[TOT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TOT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < TOT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n1_in[i] = NORM_IW'($signed(dir_reg[i]));
            n2_in[i] = NORM_IW'(c1_reg[i]);
            n3_in[i] = NORM_IW'(c2_reg[i]);
        end
    end

    lavm_norm u_norm_front (.clk(clk), .en(en), .vec_in(n1_in), .vec_out(front_w));
    lavm_norm u_norm_side  (.clk(clk), .en(en), .vec_in(n2_in), .vec_out(side_w));
    lavm_norm u_norm_camup (.clk(clk), .en(en), .vec_in(n3_in), .vec_out(camup_w));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_eye_reg <= {eye_z, eye_y, eye_x};
            i_tgt_reg <= {target_z, target_y, target_x};
            i_up_reg  <= {upref_z, upref_y, upref_x};

            for (int i = 0; i < 3; i++)
            begin
                dir_reg[i] <= 33'($signed(i_tgt_reg[i])) - 33'($signed(i_eye_reg[i]));
            end
            r_eye_reg <= i_eye_reg;
            r_up_reg  <= i_up_reg;

            d1_reg[0] <= '{eye: r_eye_reg, up: r_up_reg};
            d2_reg[0] <= '{eye: x2_eye_reg, front: x2_front_reg};
            d3_reg[0] <= '{eye: y2_eye_reg, front: y2_front_reg, side: y2_side_reg};
            for (int k = 1; k < NL; k++)
            begin
                d1_reg[k] <= d1_reg[k-1];
                d2_reg[k] <= d2_reg[k-1];
                d3_reg[k] <= d3_reg[k-1];
            end

            // front x upref
            p1_reg[0] <= PW1'($signed(front_w[1])) * PW1'($signed(d1_reg[NL-1].up[2]));
            p1_reg[1] <= PW1'($signed(front_w[2])) * PW1'($signed(d1_reg[NL-1].up[1]));
            p1_reg[2] <= PW1'($signed(front_w[2])) * PW1'($signed(d1_reg[NL-1].up[0]));
            p1_reg[3] <= PW1'($signed(front_w[0])) * PW1'($signed(d1_reg[NL-1].up[2]));
            p1_reg[4] <= PW1'($signed(front_w[0])) * PW1'($signed(d1_reg[NL-1].up[1]));
            p1_reg[5] <= PW1'($signed(front_w[1])) * PW1'($signed(d1_reg[NL-1].up[0]));
            x1_eye_reg   <= d1_reg[NL-1].eye;
            x1_front_reg <= front_w;

            for (int i = 0; i < 3; i++)
            begin
                c1_reg[i] <= CW1'(p1_reg[2*i]) - CW1'(p1_reg[2*i+1]);
            end
            x2_eye_reg   <= x1_eye_reg;
            x2_front_reg <= x1_front_reg;

            // right x front
            p2_reg[0] <= PW2'($signed(side_w[1])) * PW2'($signed(d2_reg[NL-1].front[2]));
            p2_reg[1] <= PW2'($signed(side_w[2])) * PW2'($signed(d2_reg[NL-1].front[1]));
            p2_reg[2] <= PW2'($signed(side_w[2])) * PW2'($signed(d2_reg[NL-1].front[0]));
            p2_reg[3] <= PW2'($signed(side_w[0])) * PW2'($signed(d2_reg[NL-1].front[2]));
            p2_reg[4] <= PW2'($signed(side_w[0])) * PW2'($signed(d2_reg[NL-1].front[1]));
            p2_reg[5] <= PW2'($signed(side_w[1])) * PW2'($signed(d2_reg[NL-1].front[0]));
            y1_eye_reg   <= d2_reg[NL-1].eye;
            y1_front_reg <= d2_reg[NL-1].front;
            y1_side_reg  <= side_w;

            for (int i = 0; i < 3; i++)
            begin
                c2_reg[i] <= CW2'(p2_reg[2*i]) - CW2'(p2_reg[2*i+1]);
            end
            y2_eye_reg   <= y1_eye_reg;
            y2_front_reg <= y1_front_reg;
            y2_side_reg  <= y1_side_reg;

            // translation dot products
            for (int i = 0; i < 3; i++)
            begin
                dp_reg[i]   <= PD'($signed(d3_reg[NL-1].side[i]))
                             * PD'($signed(d3_reg[NL-1].eye[i]));
                dp_reg[3+i] <= PD'($signed(camup_w[i])) * PD'($signed(d3_reg[NL-1].eye[i]));
                dp_reg[6+i] <= PD'($signed(d3_reg[NL-1].front[i]))
                             * PD'($signed(d3_reg[NL-1].eye[i]));
            end
            z1_front_reg <= d3_reg[NL-1].front;
            z1_side_reg  <= d3_reg[NL-1].side;
            z1_camup_reg <= camup_w;

            s_reg[0] <= DW'(0) - (DW'(dp_reg[0]) + DW'(dp_reg[1]) + DW'(dp_reg[2]));
            s_reg[1] <= DW'(0) - (DW'(dp_reg[3]) + DW'(dp_reg[4]) + DW'(dp_reg[5]));
            s_reg[2] <= DW'(dp_reg[6]) + DW'(dp_reg[7]) + DW'(dp_reg[8]);
            z2_front_reg <= z1_front_reg;
            z2_side_reg  <= z1_side_reg;
            z2_camup_reg <= z1_camup_reg;

            for (int i = 0; i < 3; i++)
            begin
                o_right_reg[i] <= 32'($signed(z2_side_reg[i]));
                o_camup_reg[i] <= 32'($signed(z2_camup_reg[i]));
                o_back_reg[i]  <= 32'd0 - 32'($signed(z2_front_reg[i]));
            end
            o_right_reg[3] <= round_sat(s_reg[0]);
            o_camup_reg[3] <= round_sat(s_reg[1]);
            o_back_reg[3]  <= round_sat(s_reg[2]);
        end
    end

    assign right_x     = o_right_reg[0];
    assign right_y     = o_right_reg[1];
    assign right_z     = o_right_reg[2];
    assign right_shift = o_right_reg[3];
    assign camup_x     = o_camup_reg[0];
    assign camup_y     = o_camup_reg[1];
    assign camup_z     = o_camup_reg[2];
    assign camup_shift = o_camup_reg[3];
    assign back_x      = o_back_reg[0];
    assign back_y      = o_back_reg[1];
    assign back_z      = o_back_reg[2];
    assign back_shift  = o_back_reg[3];

endmodule
